### rtl/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_defines
// Assertion macros used by the sorted priority queue top module.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int PRIO_W = 16;
	localparam int OCC_W = 5;

	typedef enum logic [1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DEQ  = 2'd1,
		KIND_PEEK = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [VAL_W-1:0]  item_value;
		logic [PRIO_W-1:0]        item_priority;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  result_value;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  val;
		logic [PRIO_W-1:0]        prio;
	} entry_t;

	// per-cycle shift controls broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} ctl_t;

endpackage

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Min-priority queue kept sorted in a row of DEPTH cells.
// ----------------------------------------------------------------------------
// One command word (enqueue, dequeue or peek) is taken per clock whenever
// start is high; busy stays low, since every command finishes in the cycle
// it is taken. The row of cells inserts or shifts out in that same cycle and
// the response word appears on result with done high in the cycle after
// the command, for a single cycle; the receiver must take it then. Smaller
// priority numbers leave first, equal priorities in arrival order. A full
// enqueue reports overflow, an empty dequeue or peek underflow, and neither
// alters the contents. Kind 3 is a no-op answered with status ok.
module sorted_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spq_pkg::cmd_t cmd,
	output logic          done,
	output spq_pkg::rsp_t result
);
	import spq_pkg::*;
	`include "sorted_priority_queue_defines.svh"

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic   accept, full, empty;
	ctl_t   ctl;
	entry_t new_item;
	entry_t chain_item [DEPTH];
	logic   chain_disp [DEPTH];
	rsp_t   rsp_d;
	logic [CNT_W-1:0] count_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	assign new_item.val  = cmd.item_value;
	assign new_item.prio = cmd.item_priority;

	always_comb begin
		ctl.enq = accept && (cmd.kind == KIND_ENQ) && !full;
		ctl.deq = accept && (cmd.kind == KIND_DEQ) && !empty;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
		logic   live;
		logic   left_disp;
		entry_t left_item;
		entry_t right_item;

		assign live = (count_q > IDX);

		if (g == 0) begin : g_head
			assign left_disp = 1'b0;
			assign left_item = new_item;
		end else begin : g_body
			assign left_disp = chain_disp[g-1];
			assign left_item = chain_item[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign right_item = '0;
		end else begin : g_mid
			assign right_item = chain_item[g+1];
		end

		spq_cell u_cell (
			.clk           (clk),
			.ctl           (ctl),
			.new_item      (new_item),
			.live          (live),
			.left_displace (left_disp),
			.left_item     (left_item),
			.right_item    (right_item),
			.displace      (chain_disp[g]),
			.item          (chain_item[g])
		);
	end

	always_comb begin
		count_d            = count_q;
		rsp_d.result_value = '0;
		rsp_d.status       = ST_OK;
		case (cmd.kind)
			KIND_ENQ: begin
				if (full) begin
					rsp_d.status = ST_OVER;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			KIND_DEQ, KIND_PEEK: begin
				if (empty) begin
					rsp_d.status = ST_UNDER;
				end else begin
					rsp_d.result_value = chain_item[0].val;
					if (cmd.kind == KIND_DEQ) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		rsp_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "count above depth")
	`SPQ_ASSERT_NEXT(a_enq_grows, ctl.enq, count_q == $past(count_q) + CNT_W'(1), "enqueue lost")
	`SPQ_ASSERT_NEXT(a_deq_head, ctl.deq, result.result_value == $past(chain_item[0].val), "bad head")
	`SPQ_ASSERT_NEXT(a_done_follows, accept, done, "response missing")
	`SPQ_ASSERT_NEXT(a_no_spurious, !accept, !done, "spurious response")

endmodule

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: keeps one entry, shifts right on insert,
// left on removal of the head.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic           clk,
	input  spq_pkg::ctl_t   ctl,
	input  spq_pkg::entry_t new_item,
	input  logic           live,
	input  logic           left_displace,
	input  spq_pkg::entry_t left_item,
	input  spq_pkg::entry_t right_item,
	output logic           displace,
	output spq_pkg::entry_t item
);
	import spq_pkg::*;

	entry_t item_q;

	// slot yields to the new word if empty or holding a strictly larger priority;
	// equal priorities stay ahead so arrival order is kept
	always_comb begin
		displace = !live || (item_q.prio > new_item.prio);
	end

	always_ff @(posedge clk) begin
		if (ctl.enq && displace) begin
			item_q <= left_displace ? left_item : new_item;
		end else if (ctl.deq) begin
			item_q <= right_item;
		end
	end

	assign item = item_q;

endmodule
